@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers for the union-find block. Both expect clk_i and rst_ni in scope.

// A property that must hold at every clock edge outside reset.
`define UFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// A condition that must never be seen at a clock edge outside reset.
`define UFS_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/ufs_pkg.sv @@
package ufs_pkg;

  // Table depth by default and the element count after reset.
  localparam int MAX_ELEMENTS_DEFAULT = 1024;
  localparam int RESET_COUNT          = 1024;

  // Fixed field widths of the ports.
  localparam int CFG_W  = 11;
  localparam int ELEM_W = 10;
  localparam int SIZE_W = 11;

  // Actions the controller asks of the datapath in one cycle.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_REJECT,
    ACT_CLEAR,
    ACT_WALK_RD,
    ACT_WALK_STEP,
    ACT_WALK_END,
    ACT_NEXT_FIND,
    ACT_COMP_RD,
    ACT_COMP_WR,
    ACT_JOIN_BIG,
    ACT_JOIN_SMALL,
    ACT_RESULT
  } act_e;

  typedef struct packed {
    act_e act;
    logic second;
  } cmd_t;

  typedef struct packed {
    logic is_root;
    logic at_root;
    logic clr_last;
    logic range_err;
    logic need_join;
    logic cfg_wr;
  } sts_t;

endpackage

@@ rtl/ufs_ctrl.sv @@
`include "assert_macros.svh"

module ufs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ufs_pkg::sts_t sts_i,
  output ufs_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_CLEAR      = 9'b000000010,
    S_WALK_RD    = 9'b000000100,
    S_WALK       = 9'b000001000,
    S_COMP_RD    = 9'b000010000,
    S_COMP_WR    = 9'b000100000,
    S_JOIN_BIG   = 9'b001000000,
    S_JOIN_SMALL = 9'b010000000,
    S_RESULT     = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic            second_q, second_d;
  ufs_pkg::act_e   act;

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    act      = ufs_pkg::ACT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (sts_i.range_err) begin
            act = ufs_pkg::ACT_REJECT;
          end else begin
            act      = ufs_pkg::ACT_LOAD;
            second_d = 1'b0;
            state_d  = S_WALK_RD;
          end
        end
      end
      S_CLEAR: begin
        act = ufs_pkg::ACT_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_WALK_RD: begin
        act     = ufs_pkg::ACT_WALK_RD;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (sts_i.is_root) begin
          act     = ufs_pkg::ACT_WALK_END;
          state_d = S_COMP_RD;
        end else begin
          act = ufs_pkg::ACT_WALK_STEP;
        end
      end
      S_COMP_RD: begin
        if (!sts_i.at_root) begin
          act     = ufs_pkg::ACT_COMP_RD;
          state_d = S_COMP_WR;
        end else if (!second_q) begin
          act      = ufs_pkg::ACT_NEXT_FIND;
          second_d = 1'b1;
          state_d  = S_WALK_RD;
        end else if (sts_i.need_join) begin
          state_d = S_JOIN_BIG;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_COMP_WR: begin
        act     = ufs_pkg::ACT_COMP_WR;
        state_d = S_COMP_RD;
      end
      S_JOIN_BIG: begin
        act     = ufs_pkg::ACT_JOIN_BIG;
        state_d = S_JOIN_SMALL;
      end
      S_JOIN_SMALL: begin
        act     = ufs_pkg::ACT_JOIN_SMALL;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        act     = ufs_pkg::ACT_RESULT;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A register write restarts the clearing pass from any state.
    if (sts_i.cfg_wr) begin
      act     = ufs_pkg::ACT_NONE;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign cmd_o.act    = act;
  assign cmd_o.second = second_q;

  `UFS_ASSERT(a_join_order, (state_q == S_JOIN_SMALL) |-> ($past(state_q) == S_JOIN_BIG))
  `UFS_ASSERT_NEVER(a_no_root_rewrite, (state_q == S_COMP_WR) && sts_i.at_root)

endmodule

@@ rtl/ufs_dp.sv @@
`include "assert_macros.svh"

module ufs_dp #(
  parameter int MAX_ELEMENTS = ufs_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ufs_pkg::cmd_t               cmd_i,
  output ufs_pkg::sts_t               sts_o,
  input  logic                        opcode_i,
  input  logic [ufs_pkg::ELEM_W-1:0]  first_element_i,
  input  logic [ufs_pkg::ELEM_W-1:0]  second_element_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ufs_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                        done_o,
  output logic [ufs_pkg::ELEM_W-1:0]  root_first_o,
  output logic [ufs_pkg::ELEM_W-1:0]  root_second_o,
  output logic                        same_set_o,
  output logic [ufs_pkg::SIZE_W-1:0]  set_size_o,
  output logic                        merged_o,
  output logic                        out_of_range_o
);

  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ENT_W  = CNT_W + 1;
  localparam int ElemW  = ufs_pkg::ELEM_W;
  localparam int SizeW  = ufs_pkg::SIZE_W;
  localparam int RstCnt = (ufs_pkg::RESET_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS
                                                                : ufs_pkg::RESET_COUNT;

  // Entry layout: top bit set for a root, whose low bits hold the set size;
  // otherwise the low bits hold the parent index.
  logic [ENT_W-1:0] mem [MAX_ELEMENTS];
  logic [ENT_W-1:0] rdata_q;

  logic             op_q;
  logic [IDX_W-1:0] a_q, b_q, cur_q, root_q, ra_q, rb_q;
  logic [CNT_W-1:0] sa_q, sb_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] clr_q;
  logic             done_q;
  logic [ElemW-1:0] root_first_q, root_second_q;
  logic             same_q, merged_q, oor_q;
  logic [SizeW-1:0] size_q;

  logic             cfg_wr;
  logic [IDX_W-1:0] a_in, b_in, parent_w, big_w, small_w;
  logic [CNT_W:0]   sum_w;
  logic             join_w, clr_last;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [ENT_W-1:0] mem_wdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  assign a_in     = IDX_W'(first_element_i);
  assign b_in     = IDX_W'(second_element_i);
  assign parent_w = rdata_q[IDX_W-1:0];
  assign big_w    = (sb_q > sa_q) ? rb_q : ra_q;
  assign small_w  = (sb_q > sa_q) ? ra_q : rb_q;
  assign sum_w    = {1'b0, sa_q} + {1'b0, sb_q};
  assign join_w   = op_q & (ra_q != rb_q);
  assign clr_last = (clr_q == IDX_W'(MAX_ELEMENTS - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cur_q;
    mem_wdata = {1'b0, CNT_W'(root_q)};
    unique case (cmd_i.act) inside
      ufs_pkg::ACT_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = {1'b1, CNT_W'(1)};
      end
      ufs_pkg::ACT_WALK_RD, ufs_pkg::ACT_COMP_RD: begin
        mem_re = 1'b1;
      end
      ufs_pkg::ACT_WALK_STEP: begin
        mem_re   = 1'b1;
        mem_addr = parent_w;
      end
      ufs_pkg::ACT_COMP_WR: begin
        mem_we = 1'b1;
      end
      ufs_pkg::ACT_JOIN_BIG: begin
        mem_we    = 1'b1;
        mem_addr  = big_w;
        mem_wdata = {1'b1, sum_w[CNT_W-1:0]};
      end
      ufs_pkg::ACT_JOIN_SMALL: begin
        mem_we    = 1'b1;
        mem_addr  = small_w;
        mem_wdata = {1'b0, CNT_W'(big_w)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(RstCnt);
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (cmd_i.act == ufs_pkg::ACT_RESULT) || (cmd_i.act == ufs_pkg::ACT_REJECT);
      if (cfg_wr) begin
        count_q <= (32'(cfg_data_i) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS)
                                                    : CNT_W'(cfg_data_i);
        clr_q   <= '0;
      end else if (cmd_i.act == ufs_pkg::ACT_CLEAR) begin
        clr_q <= clr_last ? '0 : IDX_W'(clr_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.act) inside
      ufs_pkg::ACT_LOAD: begin
        op_q  <= opcode_i;
        a_q   <= a_in;
        b_q   <= b_in;
        cur_q <= a_in;
      end
      ufs_pkg::ACT_WALK_STEP, ufs_pkg::ACT_COMP_WR: begin
        cur_q <= parent_w;
      end
      ufs_pkg::ACT_WALK_END: begin
        root_q <= cur_q;
        if (cmd_i.second) begin
          rb_q  <= cur_q;
          sb_q  <= rdata_q[CNT_W-1:0];
          cur_q <= b_q;
        end else begin
          ra_q  <= cur_q;
          sa_q  <= rdata_q[CNT_W-1:0];
          cur_q <= a_q;
        end
      end
      ufs_pkg::ACT_NEXT_FIND: begin
        cur_q <= b_q;
      end
      ufs_pkg::ACT_RESULT: begin
        root_first_q  <= ElemW'(ra_q);
        root_second_q <= ElemW'(rb_q);
        same_q        <= (ra_q == rb_q);
        size_q        <= join_w ? SizeW'(sum_w[CNT_W-1:0]) : SizeW'(sa_q);
        merged_q      <= join_w;
        oor_q         <= 1'b0;
      end
      ufs_pkg::ACT_REJECT: begin
        root_first_q  <= '0;
        root_second_q <= '0;
        same_q        <= 1'b0;
        size_q        <= '0;
        merged_q      <= 1'b0;
        oor_q         <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.is_root   = rdata_q[ENT_W-1];
  assign sts_o.at_root   = (cur_q == root_q);
  assign sts_o.clr_last  = clr_last;
  assign sts_o.range_err = (32'(first_element_i) >= 32'(count_q)) ||
                           (32'(second_element_i) >= 32'(count_q));
  assign sts_o.need_join = join_w;
  assign sts_o.cfg_wr    = cfg_wr;

  assign done_o         = done_q;
  assign root_first_o   = root_first_q;
  assign root_second_o  = root_second_q;
  assign same_set_o     = same_q;
  assign set_size_o     = size_q;
  assign merged_o       = merged_q;
  assign out_of_range_o = oor_q;

  `UFS_ASSERT(a_join_distinct, (cmd_i.act == ufs_pkg::ACT_JOIN_BIG) |-> (ra_q != rb_q))

endmodule

@@ rtl/union_find_by_size_top.sv @@
// Results: an out-of-range item gives its result in the cycle after the transfer; any other
//   item gives its result after both finds and, when two sets are joined, the join. Each
//   path walked to a root is at most log2(MAX_ELEMENTS) long.
// Throughput: one item at a time over the single-port table; a new item may transfer in
//   the cycle its predecessor's result is strobed. The receiver cannot stall.
// Reset: asynchronous, active low, followed by a clearing pass over the whole table.
//
// Structure
// ---------
// The block keeps a disjoint-set forest in a single-port memory of MAX_ELEMENTS entries.
// Each entry is either a parent pointer or, for a root, the size of its set. A controller
// state machine (ufs_ctrl) sequences the work and a datapath (ufs_dp) holds the memory,
// the working registers and the result registers; they talk only through a command
// struct and a status struct.
//
// For each item the controller runs two finds, first element first. A find walks the
// parent pointers one memory read per cycle until it reaches a root, records that root
// and its size, and then walks the same path again, reading each node and rewriting it
// to point straight at the root (in turn, as the port is shared). The second
// find therefore sees the table already compressed by the first. On a unite of two
// distinct sets the larger root takes the combined size and the smaller root is hung
// beneath it; on equal sizes the first element's root stays the root.
//
// An index at or beyond the element count is rejected in the cycle of its transfer: the
// table is left alone and a result with only the out-of-range flag set follows.
//
// The configuration channel is always ready. A transfer on it saturates the count to the
// table depth and starts a fresh clearing pass over the whole table, which sets every
// entry to a singleton. No item transfers during a clearing pass, as busy_o stays high.
module union_find_by_size_top #(
  parameter int MAX_ELEMENTS = ufs_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel: an item transfers when start_i is high and busy_o is low.
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        opcode_i,
  input  logic [ufs_pkg::ELEM_W-1:0]  first_element_i,
  input  logic [ufs_pkg::ELEM_W-1:0]  second_element_i,
  // Configuration channel carrying the element count.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ufs_pkg::CFG_W-1:0]   cfg_data_i,
  // Result channel: each result is present for exactly one cycle while done_o is high.
  output logic                        done_o,
  output logic [ufs_pkg::ELEM_W-1:0]  root_first_o,
  output logic [ufs_pkg::ELEM_W-1:0]  root_second_o,
  output logic                        same_set_o,
  output logic [ufs_pkg::SIZE_W-1:0]  set_size_o,
  output logic                        merged_o,
  output logic                        out_of_range_o
);

  ufs_pkg::cmd_t cmd;
  ufs_pkg::sts_t sts;

  // The controller decides what happens in each cycle.
  ufs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // The datapath owns the table memory and all payload registers.
  ufs_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .first_element_i  (first_element_i),
    .second_element_i (second_element_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .root_first_o     (root_first_o),
    .root_second_o    (root_second_o),
    .same_set_o       (same_set_o),
    .set_size_o       (set_size_o),
    .merged_o         (merged_o),
    .out_of_range_o   (out_of_range_o)
  );

endmodule

@@ tb/tb.sv @@
module tb;

  // Field widths and defaults taken from the block's package.
  localparam int ELEM_W      = ufs_pkg::ELEM_W;
  localparam int SIZE_W      = ufs_pkg::SIZE_W;
  localparam int CFG_W       = ufs_pkg::CFG_W;
  localparam int RESET_COUNT = ufs_pkg::RESET_COUNT;

  // The predictor's table has the same depth as the block's default table.
  localparam int TABLE_DEPTH = ufs_pkg::MAX_ELEMENTS_DEFAULT;
  // The slowest item walks two paths of log2(1024) steps each and joins two sets. The
  // settling pause at the end outlasts such an item.
  localparam int SETTLE_CYCLES = 100;
  // The watchdog's limit, in time units, covers the slowest correct run, counting the
  // clearing passes and the sender's gaps.
  localparam int TIMEOUT_UNITS = 2_000_000;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_UNITE = 1'b1
  } dsu_op_e;

  // Field order matches the concatenation of the result ports in the checker.
  typedef struct packed {
    logic [ELEM_W-1:0] root_first;
    logic [ELEM_W-1:0] root_second;
    logic              same_set;
    logic [SIZE_W-1:0] set_size;
    logic              merged;
    logic              out_of_range;
  } dsu_outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              opcode_i;
  logic [ELEM_W-1:0] first_element_i;
  logic [ELEM_W-1:0] second_element_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              done_o;
  logic [ELEM_W-1:0] root_first_o;
  logic [ELEM_W-1:0] root_second_o;
  logic              same_set_o;
  logic [SIZE_W-1:0] set_size_o;
  logic              merged_o;
  logic              out_of_range_o;

  // The predictor's copy of the forest: a parent index, or minus the set size for a root.
  int forest [TABLE_DEPTH];
  int live_count;

  // Outcomes predicted for items already transferred, oldest first.
  dsu_outcome_t pending_outcomes [$];

  int  error_count      = 0;
  int  items_sent       = 0;
  int  results_checked  = 0;
  int  merges_predicted = 0;
  int  count_writes     = 0;
  bit  gaps_on          = 1'b1;

  always #2 clk_i = ~clk_i;

  union_find_by_size_top #(
    .MAX_ELEMENTS(TABLE_DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .first_element_i (first_element_i),
    .second_element_i(second_element_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .root_first_o    (root_first_o),
    .root_second_o   (root_second_o),
    .same_set_o      (same_set_o),
    .set_size_o      (set_size_o),
    .merged_o        (merged_o),
    .out_of_range_o  (out_of_range_o)
  );

  // ---------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------

  // Every element becomes a singleton, and the count saturates to the table depth.
  function automatic void reset_forest(int count_value);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      forest[i] = -1;
    end
    live_count = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value;
  endfunction

  // Walks to the root, then points every node on the walked path straight at it.
  function automatic int find_and_compress(int node);
    int root;
    int cur;
    int nxt;
    root = node;
    while (forest[root] >= 0) begin
      root = forest[root];
    end
    cur = node;
    while (cur != root) begin
      nxt = forest[cur];
      forest[cur] = root;
      cur = nxt;
    end
    return root;
  endfunction

  // Works out the result of one item and applies its effect to the forest.
  function automatic dsu_outcome_t predict_outcome(dsu_op_e op, logic [ELEM_W-1:0] a,
                                                   logic [ELEM_W-1:0] b);
    dsu_outcome_t outcome;
    int root_a;
    int root_b;
    int major_root;
    int minor_root;
    int size_after;
    outcome = '0;
    // An index outside the elements in use leaves the table alone and raises only the flag.
    if (int'(a) >= live_count || int'(b) >= live_count) begin
      outcome.out_of_range = 1'b1;
      return outcome;
    end
    // The second find sees the table already compressed by the first.
    root_a = find_and_compress(int'(a));
    root_b = find_and_compress(int'(b));
    outcome.same_set = (root_a == root_b);
    if (op == OP_UNITE && root_a != root_b) begin
      // On equal sizes the first element's root stays the root.
      major_root = root_a;
      minor_root = root_b;
      if (forest[root_a] > forest[root_b]) begin
        major_root = root_b;
        minor_root = root_a;
      end
      forest[major_root] += forest[minor_root];
      forest[minor_root] = major_root;
      outcome.merged = 1'b1;
      size_after = -forest[major_root];
    end else begin
      size_after = -forest[root_a];
    end
    outcome.root_first  = root_a[ELEM_W-1:0];
    outcome.root_second = root_b[ELEM_W-1:0];
    outcome.set_size    = size_after[SIZE_W-1:0];
    return outcome;
  endfunction

  // ---------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------

  // Every strobed result is compared with the oldest outstanding prediction. The ports
  // are sampled at the edge that ends the strobe cycle, before the block updates them.
  always @(posedge clk_i) begin : result_check
    dsu_outcome_t got;
    dsu_outcome_t want;
    if (rst_ni && done_o) begin
      got = {root_first_o, root_second_o, same_set_o, set_size_o, merged_o, out_of_range_o};
      if (pending_outcomes.size() == 0) begin
        $error("result strobed with no item outstanding");
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        results_checked++;
        if (got.root_first !== want.root_first) begin
          $error("root_first: expected %0d, got %0d", want.root_first, got.root_first);
          error_count++;
        end
        if (got.root_second !== want.root_second) begin
          $error("root_second: expected %0d, got %0d", want.root_second, got.root_second);
          error_count++;
        end
        if (got.same_set !== want.same_set) begin
          $error("same_set: expected %0d, got %0d", want.same_set, got.same_set);
          error_count++;
        end
        if (got.set_size !== want.set_size) begin
          $error("set_size: expected %0d, got %0d", want.set_size, got.set_size);
          error_count++;
        end
        if (got.merged !== want.merged) begin
          $error("merged: expected %0d, got %0d", want.merged, got.merged);
          error_count++;
        end
        if (got.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d", want.out_of_range, got.out_of_range);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------

  // Offers one item and waits for its transfer. Now and then the sender leaves start low
  // for a while first, so that the next offer lands on a different phase of the block's
  // work. Otherwise start stays high and only the item fields change.
  task automatic send_item(dsu_op_e op, int a, int b);
    dsu_outcome_t outcome;
    if (gaps_on && $urandom_range(0, 99) < 15) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    opcode_i         <= op;
    first_element_i  <= a[ELEM_W-1:0];
    second_element_i <= b[ELEM_W-1:0];
    do @(posedge clk_i); while (busy_o);
    outcome = predict_outcome(op, a[ELEM_W-1:0], b[ELEM_W-1:0]);
    pending_outcomes.push_back(outcome);
    items_sent++;
    if (outcome.merged) begin
      merges_predicted++;
    end
  endtask

  // Lowers start and waits until every outstanding result has arrived. At least one edge
  // passes, so start is never lowered and raised again within one time step.
  task automatic wait_for_outstanding();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  // Writes the element count while the block is idle. The transfer also clears the table,
  // and the block stays busy through the clearing pass, which send_item waits out.
  task automatic write_element_count(int value);
    wait_for_outstanding();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reset_forest(value);
    count_writes++;
  endtask

  // Mostly indices within the elements in use, with a share of strays over the whole field.
  function automatic int pick_index(int stray_pct);
    if (live_count == 0 || $urandom_range(0, 99) < stray_pct) begin
      return $urandom_range(0, TABLE_DEPTH - 1);
    end
    return $urandom_range(0, live_count - 1);
  endfunction

  task automatic run_random(int n, int unite_pct, int stray_pct);
    dsu_op_e op;
    int      a;
    int      b;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < unite_pct) ? OP_UNITE : OP_QUERY;
      a  = pick_index(stray_pct);
      b  = pick_index(stray_pct);
      send_item(op, a, b);
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // Straight after reset every element is its own set of one, across the whole table.
  task automatic test_reset_state();
    send_item(OP_QUERY, 0, 0);
    send_item(OP_QUERY, TABLE_DEPTH - 1, TABLE_DEPTH - 1);
    send_item(OP_QUERY, 0, TABLE_DEPTH - 1);
  endtask

  // Union by size, the tie rule, a unite within one set, and a path of two steps that the
  // next query must compress.
  task automatic test_merge_rules();
    send_item(OP_UNITE, 5, 6);
    send_item(OP_UNITE, 7, 5);
    send_item(OP_UNITE, 5, 5);
    send_item(OP_UNITE, 10, 11);
    send_item(OP_UNITE, 5, 10);
    send_item(OP_QUERY, 11, 6);
    send_item(OP_UNITE, 6, 11);
    send_item(OP_UNITE, TABLE_DEPTH - 1, 0);
    send_item(OP_QUERY, 0, TABLE_DEPTH - 1);
  endtask

  // A count of zero rejects every index, a count of one allows only element zero, and a
  // count beyond the table saturates to the table depth.
  task automatic test_count_extremes();
    write_element_count(0);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_UNITE, 0, 0);
    write_element_count(1);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_UNITE, 0, 0);
    send_item(OP_QUERY, 0, 1);
    send_item(OP_UNITE, 1, 0);
    write_element_count((1 << CFG_W) - 1);
    send_item(OP_QUERY, TABLE_DEPTH - 1, TABLE_DEPTH - 1);
    send_item(OP_UNITE, TABLE_DEPTH - 1, TABLE_DEPTH - 2);
  endtask

  // Small universes fill up with large sets and deep paths quickly.
  task automatic test_random_small_sets();
    for (int r = 0; r < 3; r++) begin
      write_element_count($urandom_range(2, 40));
      run_random(60, 60, 8);
    end
  endtask

  task automatic test_random_wide_sets();
    write_element_count($urandom_range(41, TABLE_DEPTH - 1));
    run_random(120, 50, 10);
  endtask

  // The whole table in use, offered back to back with no idle cycles at all.
  task automatic test_random_full_table();
    gaps_on = 1'b0;
    write_element_count(TABLE_DEPTH);
    run_random(100, 50, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_saturated_count();
    write_element_count($urandom_range(TABLE_DEPTH + 1, (1 << CFG_W) - 1));
    run_random(60, 50, 0);
  endtask

  // Bursts separated by pauses in which the sender waits for every result to come back.
  task automatic test_pause_and_drain();
    write_element_count($urandom_range(8, 64));
    for (int r = 0; r < 6; r++) begin
      run_random(12, 60, 10);
      wait_for_outstanding();
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    opcode_i         = OP_QUERY;
    first_element_i  = '0;
    second_element_i = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    reset_forest(RESET_COUNT);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_merge_rules();
    test_count_extremes();
    test_random_small_sets();
    test_random_wide_sets();
    test_random_full_table();
    test_random_saturated_count();
    test_pause_and_drain();

    // Every prediction must have been matched; a further quiet spell catches stray strobes.
    wait_for_outstanding();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results, %0d of them merges,",
             items_sent, results_checked, merges_predicted);
    $display("over %0d writes of the element count, from zero to beyond the table depth.",
             count_writes);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog in case a transfer or a result never comes.
  initial begin
    #(TIMEOUT_UNITS);
    $display("Timed out with %0d results outstanding.", pending_outcomes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
